/* rtl/ohp_pkg.sv */
package ohp_pkg;

    localparam int ANGLE_W  = 16;
    localparam int WEIGHT_W = 16;
    localparam int TOTAL_W  = 32;
    localparam int RATIO_W  = 8;
    localparam int CMD_W    = 2;
    localparam int DIV_NW   = 48;
    localparam int DIV_DW   = 34;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                   input logic [TOTAL_W-1:0] b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOTAL_W] ? '1 : s[TOTAL_W-1:0];
    endfunction

endpackage

/* rtl/orientation_histogram_peaks_top.sv */
// channel | dir | tdata                          | tuser        | tlast
// s_      | in  | [15:0] angle, [31:16] weight   | [1:0] command| -
// m_      | out | [15:0] peak_angle              | [0] status   | is_last
// clear: empties the bins; add: two multiplies, read-modify-write of two bins.
// query: the first beat waits on the two bin scans and the 48-step serial divide of
//   the vertex offset, a second peak on the divide alone (a flat parabola skips
//   the divide); an empty histogram skips the second scan and the divide.
// Reset clears the bins at once through per-bin valid flags; no sweep.
// A result waiting on m_ holds the sequencer only when the next result is ready.
module orientation_histogram_peaks_top #(
    parameter int BINS = 36
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] sample_angle, [31:16] sample_weight
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] peak_angle
    output logic [0:0]  m_tuser,   // [0] status
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);
    import ohp_pkg::*;

    localparam int IW = $clog2(BINS);
    localparam int CW = $clog2(BINS + 1);
    localparam int PW = 16 + $clog2(BINS + 1);
    localparam int QW = 25;
    localparam int RS = PW + $clog2(BINS);
    localparam logic [PW+1:0] RM = (PW+2)'(((64'd1 << RS) + 64'(BINS - 1)) / 64'(BINS));

    typedef enum logic [19:0] {
        S_IDLE  = 20'd1 << 0,  S_ADD0  = 20'd1 << 1,  S_ADD1  = 20'd1 << 2,
        S_ADD2  = 20'd1 << 3,  S_ADD3  = 20'd1 << 4,  S_SCAN1 = 20'd1 << 5,
        S_LIMIT = 20'd1 << 6,  S_SCAN2 = 20'd1 << 7,  S_RF0   = 20'd1 << 8,
        S_RF1   = 20'd1 << 9,  S_RF2   = 20'd1 << 10, S_RF3   = 20'd1 << 11,
        S_RF4   = 20'd1 << 12, S_RF5   = 20'd1 << 13, S_DIV1  = 20'd1 << 14,
        S_POS   = 20'd1 << 15, S_POS2  = 20'd1 << 16, S_DIV2  = 20'd1 << 17,
        S_EMIT  = 20'd1 << 18, S_SPARE = 20'd1 << 19
    } state_t;

    state_t state_reg, state_next;

    logic [RATIO_W-1:0]  ratio_reg;
    logic [ANGLE_W-1:0]  angle_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [PW-1:0]       pos_reg;
    logic [IW-1:0]       i_reg, nbi_reg;
    logic [WEIGHT_W-1:0] nb_reg;
    logic [BINS-1:0]     vld_reg;
    logic                rvld_reg;
    logic [CW-1:0]       cnt_reg;
    logic                pend_reg;
    logic [IW-1:0]       pidx_reg;
    logic [TOTAL_W-1:0]  best_reg, best2_reg;
    logic [IW-1:0]       first_reg, second_reg, target_reg;
    logic                have2_reg, on_second_reg;
    logic [TOTAL_W+RATIO_W-1:0] limit_reg;
    logic [TOTAL_W-1:0]  yp_reg, yc_reg, yn_reg;
    logic signed [32:0]  num_reg;
    logic signed [34:0]  den_reg;
    logic signed [16:0]  off_reg;
    logic [QW-1:0]       p_reg;
    logic [15:0]         q_reg;
    logic [15:0]         res_angle_reg;
    logic                res_status_reg, res_last_reg;
    logic                m_valid_reg, m_last_reg, m_status_reg;
    logic [15:0]         m_data_reg;

    logic                ram_we;
    logic [IW-1:0]       ram_waddr, ram_raddr;
    logic [TOTAL_W-1:0]  ram_wdata, ram_rdata, rd_val;

    logic                div_start, div_busy, div_done;
    logic [DIV_NW-1:0]   div_n, div_q;
    logic [DIV_DW-1:0]   div_d;

    logic                s_acc, emit_load;
    logic [CMD_W-1:0]    cmd;
    logic [IW-1:0]       a_i, a_nbi, prev_i, next_i;
    logic [15:0]         a_f, a_d;
    logic [31:0]         nb_prod;
    logic [32:0]         an_full;
    logic [31:0]         an;
    logic [DIV_DW-1:0]   ad;
    logic [34:0]         ad_full;
    logic [16:0]         mag;
    logic [25:0]         p_raw;
    logic [PW-1:0]       q_in;
    logic [2*PW+1:0]     q_prod;

    assign cmd    = s_tuser;
    assign s_tready = (state_reg == S_IDLE);
    assign s_acc  = s_tvalid && s_tready;
    assign rd_val = rvld_reg ? ram_rdata : '0;
    assign emit_load = (state_reg == S_EMIT) && (!m_valid_reg || m_tready);

    ohp_ram #(.WIDTH(TOTAL_W), .DEPTH(BINS)) u_ram (
        .clk(aclk), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
        .rd_addr(ram_raddr), .rd_data(ram_rdata)
    );

    ohp_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_n),
        .divisor(div_d), .busy(div_busy), .done(div_done), .quotient(div_q)
    );

    always_comb begin
        a_i = IW'(pos_reg >> 16);
        a_f = pos_reg[15:0];
        if (a_f <= 16'd32768) begin
            a_d   = 16'd32768 - a_f;
            a_nbi = (a_i == '0) ? IW'(BINS - 1) : IW'(a_i - 1'b1);
        end else begin
            a_d   = a_f - 16'd32768;
            a_nbi = (a_i == IW'(BINS - 1)) ? '0 : IW'(a_i + 1'b1);
        end
        nb_prod = weight_reg * a_d;
        prev_i  = (target_reg == '0) ? IW'(BINS - 1) : IW'(target_reg - 1'b1);
        next_i  = (target_reg == IW'(BINS - 1)) ? '0 : IW'(target_reg + 1'b1);
        an_full = num_reg[32] ? 33'(-num_reg) : 33'(num_reg);
        an      = an_full[31:0];
        ad_full = den_reg[34] ? 35'(-den_reg) : 35'(den_reg);
        ad      = ad_full[DIV_DW-1:0];
        mag     = (div_q > DIV_NW'(32768)) ? 17'd32768 : div_q[16:0];
        p_raw   = 26'({target_reg, 16'h0000}) + 26'd32768 + 26'(off_reg);
        q_in    = PW'(p_reg) + PW'(BINS / 2);
        q_prod  = q_in * RM;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = i_reg;
        ram_wdata = '0;
        ram_raddr = '0;
        div_start = 1'b0;
        div_n     = DIV_NW'({an, 15'h0000}) + DIV_NW'(ad >> 1);
        div_d     = ad;
        unique case (state_reg)
            S_ADD1: ram_raddr = a_i;
            S_ADD2: begin
                ram_we    = 1'b1;
                ram_waddr = i_reg;
                ram_wdata = sat_add(rd_val, TOTAL_W'(weight_reg - nb_reg));
                ram_raddr = nbi_reg;
            end
            S_ADD3: begin
                ram_we    = 1'b1;
                ram_waddr = nbi_reg;
                ram_wdata = sat_add(rd_val, TOTAL_W'(nb_reg));
            end
            S_SCAN1, S_SCAN2: ram_raddr = cnt_reg[IW-1:0];
            S_RF0: ram_raddr = prev_i;
            S_RF1: ram_raddr = target_reg;
            S_RF2: ram_raddr = next_i;
            S_RF5: div_start = (den_reg != '0);
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_acc && cmd == CMD_ADD) state_next = S_ADD0;
                else if (s_acc && cmd == CMD_QUERY) state_next = S_SCAN1;
            end
            S_ADD0:  state_next = S_ADD1;
            S_ADD1:  state_next = S_ADD2;
            S_ADD2:  state_next = S_ADD3;
            S_ADD3:  state_next = S_IDLE;
            S_SCAN1: if (cnt_reg == CW'(BINS)) state_next = S_LIMIT;
            S_LIMIT: state_next = (best_reg == '0) ? S_EMIT : S_SCAN2;
            S_SCAN2: if (cnt_reg == CW'(BINS)) state_next = S_RF0;
            S_RF0:   state_next = S_RF1;
            S_RF1:   state_next = S_RF2;
            S_RF2:   state_next = S_RF3;
            S_RF3:   state_next = S_RF4;
            S_RF4:   state_next = S_RF5;
            S_RF5:   state_next = (den_reg != '0) ? S_DIV1 : S_POS;
            S_DIV1:  if (div_done) state_next = S_POS;
            S_POS:   state_next = S_POS2;
            S_POS2:  state_next = S_DIV2;
            S_DIV2:  state_next = S_EMIT;
            S_EMIT: begin
                if (emit_load) state_next = res_last_reg ? S_IDLE : S_RF0;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ratio_reg   <= 8'd205;
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
            rvld_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) ratio_reg <= cfg_wdata;
            if (s_acc && cmd == CMD_CLEAR) vld_reg <= '0;
            else if (ram_we) vld_reg[ram_waddr] <= 1'b1;
            rvld_reg <= vld_reg[ram_raddr];
            pend_reg <= (state_reg == S_SCAN1 || state_reg == S_SCAN2)
                        && cnt_reg != CW'(BINS);
            if (emit_load) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        pidx_reg <= cnt_reg[IW-1:0];
        if (s_acc) begin
            angle_reg  <= s_tdata[15:0];
            weight_reg <= s_tdata[31:16];
            cnt_reg    <= '0;
            best_reg   <= '0;
        end
        unique case (state_reg)
            S_ADD0: pos_reg <= PW'(angle_reg * BINS);
            S_ADD1: begin
                i_reg   <= a_i;
                nbi_reg <= a_nbi;
                nb_reg  <= nb_prod[31:16];
            end
            S_SCAN1: begin
                if (cnt_reg != CW'(BINS)) cnt_reg <= cnt_reg + 1'b1;
                if (pend_reg && rd_val > best_reg) begin
                    best_reg  <= rd_val;
                    first_reg <= pidx_reg;
                end
            end
            S_LIMIT: begin
                limit_reg      <= best_reg * ratio_reg;
                cnt_reg        <= '0;
                best2_reg      <= '0;
                have2_reg      <= 1'b0;
                target_reg     <= first_reg;
                on_second_reg  <= 1'b0;
                res_angle_reg  <= '0;
                res_status_reg <= 1'b1;
                res_last_reg   <= 1'b1;
            end
            S_SCAN2: begin
                if (cnt_reg != CW'(BINS)) cnt_reg <= cnt_reg + 1'b1;
                if (pend_reg && pidx_reg != first_reg && rd_val > best2_reg
                    && {rd_val, 8'h00} > limit_reg) begin
                    best2_reg  <= rd_val;
                    second_reg <= pidx_reg;
                    have2_reg  <= 1'b1;
                end
            end
            S_RF1: yp_reg <= rd_val;
            S_RF2: yc_reg <= rd_val;
            S_RF3: yn_reg <= rd_val;
            S_RF4: begin
                num_reg <= $signed({1'b0, yp_reg}) - $signed({1'b0, yn_reg});
                den_reg <= $signed({3'b000, yp_reg}) - $signed({2'b00, yc_reg, 1'b0})
                           + $signed({3'b000, yn_reg});
            end
            S_RF5: off_reg <= '0;
            S_DIV1: begin
                if (div_done) off_reg <= (num_reg[32] != den_reg[34]) ?
                                         -$signed(mag) : $signed(mag);
            end
            S_POS: begin
                if (p_raw >= 26'(BINS * 65536)) p_reg <= QW'(p_raw - 26'(BINS * 65536));
                else p_reg <= QW'(p_raw);
            end
            S_POS2: q_reg <= q_prod[RS+15:RS];
            S_DIV2: begin
                res_angle_reg  <= 16'(17'h10000 - {1'b0, q_reg});
                res_status_reg <= 1'b0;
                res_last_reg   <= on_second_reg || !have2_reg;
            end
            S_EMIT: begin
                if (emit_load) begin
                    target_reg    <= second_reg;
                    on_second_reg <= 1'b1;
                end
            end
            default: ;
        endcase
        if (emit_load) begin
            m_data_reg   <= res_angle_reg;
            m_status_reg <= res_status_reg;
            m_last_reg   <= res_last_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_status_reg;
    assign m_tlast    = m_last_reg;

`ifndef SYNTHESIS
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("empty status without last");
    a_rmw_split: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ADD2) |-> (ram_waddr != ram_raddr))
        else $error("bin write and read collide");
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && cmd == CMD_CLEAR) |=> (vld_reg == '0))
        else $error("clear left a bin valid");
`endif
endmodule

/* rtl/ohp_ram.sv */
module ohp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 36
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

/* rtl/ohp_div.sv */
module ohp_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [ohp_pkg::DIV_NW-1:0] dividend,
    input  logic [ohp_pkg::DIV_DW-1:0] divisor,
    output logic                       busy,
    output logic                       done,
    output logic [ohp_pkg::DIV_NW-1:0] quotient
);
    import ohp_pkg::*;

    localparam int CW = $clog2(DIV_NW + 1);

    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW-1:0] dsr_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg, done_reg;
    logic [DIV_DW:0]   shifted;

    always_comb begin
        shifted = {rem_reg, quo_reg[DIV_NW-1]};
        if (shifted >= {1'b0, dsr_reg}) begin
            rem_next = DIV_DW'(shifted - {1'b0, dsr_reg});
            quo_next = {quo_reg[DIV_NW-2:0], 1'b1};
        end else begin
            rem_next = shifted[DIV_DW-1:0];
            quo_next = {quo_reg[DIV_NW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dsr_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DIV_NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
